FILE: rtl/core/mrms_pkg.sv
// ----------------------------------------------------------------------------
// mrms_pkg: shared types and constants for the moving RMS block
// Sample and result widths, the control sequencer states and the status
// group that the square root unit reports back.
// ----------------------------------------------------------------------------
package mrms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RMS_W    = 16;
  // Square of a 16-bit two's complement sample: at most 2^30.
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int STEP_W   = $clog2(RMS_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [RMS_W-1:0]    rms_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT
  } mrms_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

FILE: rtl/core/mrms_root.sv
// ----------------------------------------------------------------------------
// mrms_root: iterative floor(sqrt(total / WINDOW_LEN))
// Finds the largest r with WINDOW_LEN * r^2 <= total, one result bit per
// cycle, from the top bit down, with shift-and-add updates only.
// ----------------------------------------------------------------------------
module mrms_root #(
  parameter int WINDOW_LEN = 64,
  parameter int TOT_W      = 37
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TOT_W-1:0]    total,
  output mrms_pkg::root_stat_t stat,
  output mrms_pkg::rms_t      root
);
  import mrms_pkg::*;

  // Trial values reach WINDOW_LEN * 2^32; one spare bit for the sum.
  localparam int ACC_W = TOT_W + 2;
  localparam logic [ACC_W-1:0] B_INIT =
    ACC_W'(WINDOW_LEN) << (2 * (RMS_W - 1));
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RMS_W - 1);

  logic [TOT_W-1:0]  tot_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;   // WINDOW_LEN * r^2
  logic [ACC_W-1:0]  a_r, a_nxt;       // (WINDOW_LEN * r) << (k + 1)
  logic [ACC_W-1:0]  b_r, b_nxt;       // WINDOW_LEN << 2k
  logic [RMS_W-1:0]  root_r, root_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [ACC_W-1:0]  trial;
  logic              take;

  always_comb begin
    trial    = acc_r + a_r + b_r;
    take     = (trial <= ACC_W'(tot_r));
    acc_nxt  = take ? trial : acc_r;
    a_nxt    = (a_r + (take ? (b_r << 1) : '0)) >> 1;
    b_nxt    = b_r >> 2;
    root_nxt = {root_r[RMS_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tot_r  <= total;
      acc_r  <= '0;
      a_r    <= '0;
      b_r    <= B_INIT;
      root_r <= '0;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

FILE: rtl/core/moving_rms.sv
// ----------------------------------------------------------------------------
// moving_rms: sliding-window RMS of a signed sample stream
// Keeps the last WINDOW_LEN samples in a window memory and a running sum of
// their squares; each request returns floor(sqrt(sum / WINDOW_LEN)).
// ----------------------------------------------------------------------------
//
//  channel   ports                            direction   payload
//  --------  -------------------------------  ----------  -----------------
//  input     in_valid, in_stall, in_sample    in          signed 16 bits
//  result    out_valid, out_stall, out_rms    out         unsigned 16 bits
//
//  A request passes through accepting the sample, a memory read, the two
//  squares with the write back, the running sum, the bit-serial square
//  root, and the load of the result register, which waits while a stalled
//  result still holds that register. The square root loop sets the rate.
//  Reset (rst_n low, synchronous) empties the sequencer; the window memory
//  is not swept: a wrap flag makes slots not yet written read as zero.
//  A stalled result waits in the output register while the next request is
//  taken; the root result holds until that register frees up.
// ----------------------------------------------------------------------------
module moving_rms #(
  parameter int WINDOW_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrms_pkg::sample_t  in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output mrms_pkg::rms_t     out_rms
);
  import mrms_pkg::*;

  localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  // Sum of squares is at most WINDOW_LEN * 2^30.
  localparam int TOT_W  = SQ_W + $clog2(WINDOW_LEN);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_LEN - 1);

  // Window memory: one write and one read port, registered read data.
  logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
  logic [SAMPLE_W-1:0] rd_data_r;

  mrms_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic              wrapped_r, wrapped_nxt;
  sample_t           sample_r;
  logic [SQ_W-1:0]   sq_new_r, sq_old_r;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              out_valid_r;
  rms_t              out_rms_r;

  logic              accept, rd_en, wr_en, root_start, out_load;
  sample_t           old_sample;
  logic signed [2*SAMPLE_W-1:0] prod_new, prod_old;
  root_stat_t        root_stat;
  rms_t              root_val;

  // Slots past the write pointer were never written before the first wrap:
  // treat them as zeros, since reset does not sweep the window memory.
  assign old_sample = wrapped_r ? sample_t'(rd_data_r) : '0;
  assign prod_new   = sample_r * sample_r;
  assign prod_old   = old_sample * old_sample;
  assign total_nxt  = total_r - TOT_W'(sq_old_r) + TOT_W'(sq_new_r);

  assign accept = in_valid && !in_stall;

  // Sequencer: next state and strobes.
  always_comb begin
    state_nxt   = state_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    root_start  = 1'b0;
    out_load    = 1'b0;
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        // Fetch the sample that leaves the window.
        rd_en     = 1'b1;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        // Overwrite the oldest slot and advance the pointer.
        wr_en = 1'b1;
        if (slot_r == LAST_SLOT) begin
          slot_nxt    = '0;
          wrapped_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        // Hold the root until the result register can take it.
        if (root_stat.done && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      if (root_start) total_r <= total_nxt;
    end
  end

  // Window memory ports.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= win_mem[slot_r];
    if (wr_en) win_mem[slot_r] <= sample_r;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) sample_r <= in_sample;
    if (state_r == ST_SQUARE) begin
      sq_new_r <= prod_new[SQ_W-1:0];
      sq_old_r <= prod_old[SQ_W-1:0];
    end
  end

  // Result register: drop the valid once the request is taken downstream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_rms_r <= root_val;
  end

  mrms_root #(
    .WINDOW_LEN (WINDOW_LEN),
    .TOT_W      (TOT_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .total (total_nxt),
    .stat  (root_stat),
    .root  (root_val)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rms   = out_rms_r;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the moving RMS block
// Streams signed samples into moving_rms, predicts every result from a
// private copy of the sliding window and its running sum of squares, and
// compares each result, in order, against the prediction.
// ----------------------------------------------------------------------------
module testbench #(
  // Window length of the block under test. Override it to 1 for the
  // window-of-one case; the prediction follows it.
  parameter int WIN_LEN = 64
);

  timeunit 1ns;
  timeprecision 1ps;

  import mrms_pkg::*;

  // --------------------------------------------------------------------------
  // Predicted RMS results, kept in request order
  // --------------------------------------------------------------------------
  class rms_scoreboard;
    int unsigned     win_len;
    sample_t         history[];
    int unsigned     oldest;
    longint unsigned sq_acc;
    rms_t            rms_expected[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     full_scale_hits;

    function new(int unsigned len);
      win_len    = len;
      history    = new[len];
      foreach (history[i]) history[i] = '0;
      oldest     = 0;
      sq_acc     = 0;
    endfunction

    function void note_sample(sample_t s);
      longint signed   old_v;
      longint signed   new_v;
      longint unsigned mean;
      longint unsigned root;
      longint unsigned trial;
      old_v = history[oldest];
      new_v = s;
      // Swap the leaving square for the fresh one; the sum stays exact.
      sq_acc = sq_acc - longint'(old_v * old_v) + longint'(new_v * new_v);
      history[oldest] = s;
      oldest = (oldest + 1) % win_len;
      mean = sq_acc / win_len;
      // Build the floor root one bit at a time, top bit first.
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean) root = trial;
      end
      rms_expected.push_back(rms_t'(root));
    endfunction

    function void check_rms(rms_t got);
      rms_t want;
      if (rms_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: unexpected rms result, expected none, got %0d", $time, got);
        return;
      end
      want = rms_expected.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: rms mismatch, expected %0d, got %0d", $time, want, got);
      end else if (want == rms_t'(32768)) begin
        full_scale_hits++;
      end
    endfunction

    function int pending();
      return rms_expected.size();
    endfunction
  endclass

  // Shapes of the random sample bursts
  typedef enum int {
    BURST_NOISE,      // uniform over the whole 16-bit range
    BURST_FLOOR_NEG,  // a full window of -32768: drives rms to 32768
    BURST_CEIL_POS,   // a full window of +32767
    BURST_QUIET,      // tiny magnitudes around zero
    BURST_SWING,      // alternating full-scale extremes
    BURST_SILENCE     // zeros: drains the window back toward zero
  } burst_kind_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input is known from time zero
  // --------------------------------------------------------------------------
  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  sample_t in_sample = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  rms_t    out_rms;

  // Receiver long hold, raised by its own counting process
  logic    stall_hold = 1'b0;

  // Idle rates in percent, changed per phase by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent          = 0;

  rms_scoreboard sb = new(WIN_LEN);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  moving_rms #(
    .WINDOW_LEN (WIN_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rms   (out_rms)
  );

  // --------------------------------------------------------------------------
  // Sender: offer one request, hold it until the block takes it
  // --------------------------------------------------------------------------
  task automatic send_sample(input sample_t value);
    // Idle a random number of cycles before the request.
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    // Hold valid and payload until an edge sees valid high and stall low.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(value);
    sent++;
  endtask

  // Hold off the result channel for a fixed stretch of cycles.
  task automatic hold_results(input int unsigned cycles);
    stall_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    stall_hold <= 1'b0;
  endtask

  // Pause the sender until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each accepted result, then pick the next stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    // Values read here are the ones the edge sampled.
    if (rst_n && out_valid && !out_stall) sb.check_rms(out_rms);
    out_stall <= stall_hold || ($urandom_range(99, 0) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    sample_t corner_samples[];
    int unsigned phase_goal;
    int unsigned run_len;
    burst_kind_t kind;

    corner_samples = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
      16'h0002, 16'hFFFE, 16'h00B5, 16'hFF4A, 16'h1000, 16'h7FFE, 16'h8001,
      16'h0000, 16'h3039, 16'hC000, 16'h4000
    };

    // Hold reset low, then release it on a clock edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners. The first ones land in a window still full of the
    // zeros from reset, which checks the early-window divisor.
    send_idle_pct = 12;
    recv_idle_pct = 87;
    foreach (corner_samples[i]) send_sample(corner_samples[i]);

    // Three idling phases: busy sender with a sparse receiver, then the
    // reverse, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 12 : 0;
      // Back up the result channel for a long stretch while requests keep
      // coming, so the block fills and stalls its input.
      if (phase == 2) begin
        fork
          hold_results(400);
        join_none
      end
      phase_goal = sent + 630;
      while (sent < phase_goal) begin
        kind = burst_kind_t'($urandom_range(BURST_SILENCE, BURST_NOISE));
        case (kind)
          BURST_NOISE: begin
            run_len = $urandom_range(40, 1);
            repeat (run_len) send_sample(sample_t'($urandom));
          end
          BURST_FLOOR_NEG: begin
            run_len = WIN_LEN + $urandom_range(8, 0);
            repeat (run_len) send_sample(16'h8000);
          end
          BURST_CEIL_POS: begin
            run_len = WIN_LEN + $urandom_range(8, 0);
            repeat (run_len) send_sample(16'h7FFF);
          end
          BURST_QUIET: begin
            run_len = $urandom_range(30, 1);
            repeat (run_len) send_sample(sample_t'(int'($urandom_range(16, 0)) - 8));
          end
          BURST_SWING: begin
            run_len = $urandom_range(40, 2);
            for (int k = 0; k < run_len; k++)
              send_sample(k[0] ? 16'h7FFF : 16'h8000);
          end
          default: begin
            run_len = $urandom_range(WIN_LEN, 1);
            repeat (run_len) send_sample('0);
          end
        endcase
      end
      // Drain before the next phase.
      wait_drained();
    end

    // Wait out the block's latency for any stray result.
    repeat (40) @(posedge clk);

    $display("Sent %0d samples over a %0d-entry window, checked %0d rms results",
             sent, WIN_LEN, sb.checked);
    $display("Full-scale rms seen %0d times, %0d mismatches", sb.full_scale_hits,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
